// ===== hw/rtl/gga_pkg.sv =====
// ----------------------------------------------------------------------------
// gga_pkg
// constants, character codes and helper functions for the gga fix parser
// ----------------------------------------------------------------------------
package gga_pkg;

   localparam int COORD_FRACTION_DIGITS_DEFAULT = 4;

   localparam logic [26:0] LAT_MAX = 27'd99999999;
   localparam logic [29:0] LON_MAX = 30'd999999999;
   localparam logic [6:0]  SEC_MAX = 7'd99;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_HEM   = 2'd1;
   localparam logic [1:0] STATUS_NON_DIGIT = 2'd2;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_W     = 8'h57;

   // powers of ten up to 10^6
   function automatic logic [19:0] pow10(input logic [2:0] idx);
      logic [19:0] v;
      case (idx)
         3'd0:    v = 20'd1;
         3'd1:    v = 20'd10;
         3'd2:    v = 20'd100;
         3'd3:    v = 20'd1000;
         3'd4:    v = 20'd10000;
         3'd5:    v = 20'd100000;
         3'd6:    v = 20'd1000000;
         default: v = 20'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/nmea_gga_fix_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_gga_fix_parser
// character-serial parser for gga sentences: time, latitude and longitude
// ----------------------------------------------------------------------------
// a result is presented from the result register after the character that
//   completes it has passed the input register; a pending result that is
//   not yet taken stalls the transfer in between
// throughput: one character per cycle while rsp_ready is high
// reset: synchronous, active high; parser goes idle and waits for a start
// ----------------------------------------------------------------------------
module nmea_gga_fix_parser
   import gga_pkg::*;
#(
   parameter int COORD_FRACTION_DIGITS = COORD_FRACTION_DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_start_req,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_hour,
   output logic [6:0]  rsp_minute,
   output logic [6:0]  rsp_second,
   output logic [19:0] rsp_microsecond,
   output logic [26:0] rsp_latitude,
   output logic [29:0] rsp_longitude,
   output logic        rsp_north,
   output logic        rsp_east,
   output logic [1:0]  rsp_status
);

   localparam int FRAC_DIGITS = (COORD_FRACTION_DIGITS > 6) ? 6 : COORD_FRACTION_DIGITS;
   localparam logic [2:0] FRAC_LAST = 3'(FRAC_DIGITS - 1);
   localparam logic [2:0] FRAC_NUM  = 3'(FRAC_DIGITS);

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_HEADER   = 4'd1;
   localparam logic [3:0] PH_HHMM     = 4'd2;
   localparam logic [3:0] PH_SEC_INT  = 4'd3;
   localparam logic [3:0] PH_SEC_FRAC = 4'd4;
   localparam logic [3:0] PH_LAT_INT  = 4'd5;
   localparam logic [3:0] PH_LAT_FRAC = 4'd6;
   localparam logic [3:0] PH_LAT_HEM  = 4'd7;
   localparam logic [3:0] PH_LAT_SEP  = 4'd8;
   localparam logic [3:0] PH_LON_INT  = 4'd9;
   localparam logic [3:0] PH_LON_FRAC = 4'd10;
   localparam logic [3:0] PH_LON_HEM  = 4'd11;
   localparam logic [3:0] PH_DONE     = 4'd12;

   // input register
   logic       in_valid_ff;
   logic       in_start_ff;
   logic [7:0] in_char_ff;

   // parser state
   logic [3:0]  phase_ff, phase_in;
   logic [2:0]  tpos_ff, tpos_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  sec_ff, sec_in;
   logic [19:0] micro_ff, micro_in;
   logic [2:0]  fcount_ff, fcount_in;
   logic [26:0] lat_ff, lat_in;
   logic [29:0] lon_ff, lon_in;
   logic        north_ff, north_in;

   // result register
   logic        rsp_valid_ff;
   logic [6:0]  rsp_hour_ff, rsp_minute_ff, rsp_second_ff;
   logic [19:0] rsp_micro_ff;
   logic [26:0] rsp_lat_ff;
   logic [29:0] rsp_lon_ff;
   logic        rsp_north_ff, rsp_east_ff;
   logic [1:0]  rsp_status_ff;

   logic        advance;
   logic        is_dig;
   logic [3:0]  digit;
   logic        emit;
   logic        emit_east;
   logic [1:0]  emit_status;

   logic [10:0] hm_sum;
   logic [9:0]  sec_sum;
   logic [23:0] int_add;
   logic [23:0] frac_add;
   logic [23:0] micro_add;
   logic [30:0] lat_int_sum;
   logic [33:0] lon_int_sum;
   logic [30:0] lat_frac_sum;
   logic [30:0] lon_frac_sum;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign is_dig = in_char_ff inside {[CH_ZERO:CH_NINE]};
   assign digit  = is_dig ? 4'(in_char_ff - CH_ZERO) : 4'd0;

   // digit accumulate datapaths
   always_comb begin
      hm_sum       = ((tpos_ff < 3'd2) ? 11'(hour_ff) : 11'(minute_ff)) * 11'd10
                     + 11'(digit);
      sec_sum      = 10'(sec_ff) * 10'd10 + 10'(digit);
      int_add      = 24'(digit) * 24'(pow10(FRAC_NUM));
      frac_add     = 24'(digit) * 24'(pow10(FRAC_LAST - fcount_ff));
      micro_add    = 24'(digit) * 24'(pow10(3'd5 - fcount_ff));
      lat_int_sum  = 31'(lat_ff) * 31'd10 + 31'(int_add);
      lon_int_sum  = 34'(lon_ff) * 34'd10 + 34'(int_add);
      lat_frac_sum = 31'(lat_ff) + 31'(frac_add);
      lon_frac_sum = 31'(lon_ff) + 31'(frac_add);
   end

   always_comb begin
      phase_in    = phase_ff;
      tpos_in     = tpos_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      sec_in      = sec_ff;
      micro_in    = micro_ff;
      fcount_in   = fcount_ff;
      lat_in      = lat_ff;
      lon_in      = lon_ff;
      north_in    = north_ff;
      emit        = 1'b0;
      emit_east   = 1'b0;
      emit_status = STATUS_OK;
      if (in_start_ff) begin
         // new sentence: clear everything, this character is header
         tpos_in   = '0;
         hour_in   = '0;
         minute_in = '0;
         sec_in    = '0;
         micro_in  = '0;
         fcount_in = '0;
         lat_in    = '0;
         lon_in    = '0;
         north_in  = 1'b0;
         phase_in  = (in_char_ff == CH_COMMA) ? PH_HHMM : PH_HEADER;
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               if (in_char_ff == CH_COMMA) phase_in = PH_HHMM;
            end
            PH_HHMM: begin
               if (!is_dig) begin
                  emit        = 1'b1;
                  emit_status = STATUS_NON_DIGIT;
               end else begin
                  if (tpos_ff < 3'd2) hour_in = hm_sum[6:0];
                  else minute_in = hm_sum[6:0];
                  tpos_in = tpos_ff + 3'd1;
                  if (tpos_ff >= 3'd3) phase_in = PH_SEC_INT;
               end
            end
            PH_SEC_INT: begin
               if (in_char_ff == CH_DOT) begin
                  phase_in  = PH_SEC_FRAC;
                  fcount_in = '0;
               end else if (!is_dig) begin
                  emit        = 1'b1;
                  emit_status = STATUS_NON_DIGIT;
               end else begin
                  sec_in = (sec_sum > 10'(SEC_MAX)) ? SEC_MAX : sec_sum[6:0];
               end
            end
            PH_SEC_FRAC: begin
               if (in_char_ff == CH_COMMA) begin
                  phase_in  = PH_LAT_INT;
                  fcount_in = '0;
               end else if (!is_dig) begin
                  emit        = 1'b1;
                  emit_status = STATUS_NON_DIGIT;
               end else if (fcount_ff < 3'd6) begin
                  micro_in  = micro_ff + micro_add[19:0];
                  fcount_in = fcount_ff + 3'd1;
               end
            end
            PH_LAT_INT: begin
               if (in_char_ff == CH_DOT) begin
                  phase_in  = PH_LAT_FRAC;
                  fcount_in = '0;
               end else if (!is_dig) begin
                  emit        = 1'b1;
                  emit_status = STATUS_NON_DIGIT;
               end else begin
                  lat_in = (lat_int_sum > 31'(LAT_MAX)) ? LAT_MAX : lat_int_sum[26:0];
               end
            end
            PH_LAT_FRAC: begin
               if (in_char_ff == CH_COMMA) begin
                  phase_in = PH_LAT_HEM;
               end else if (!is_dig) begin
                  emit        = 1'b1;
                  emit_status = STATUS_NON_DIGIT;
               end else if (fcount_ff < FRAC_NUM) begin
                  lat_in    = (lat_frac_sum > 31'(LAT_MAX)) ? LAT_MAX : lat_frac_sum[26:0];
                  fcount_in = fcount_ff + 3'd1;
               end
            end
            PH_LAT_HEM: begin
               north_in = (in_char_ff == CH_N);
               if (in_char_ff inside {CH_N, CH_S}) begin
                  phase_in = PH_LAT_SEP;
               end else begin
                  emit        = 1'b1;
                  emit_status = STATUS_BAD_HEM;
               end
            end
            PH_LAT_SEP: begin
               phase_in = PH_LON_INT;
            end
            PH_LON_INT: begin
               if (in_char_ff == CH_DOT) begin
                  phase_in  = PH_LON_FRAC;
                  fcount_in = '0;
               end else if (!is_dig) begin
                  emit        = 1'b1;
                  emit_status = STATUS_NON_DIGIT;
               end else begin
                  lon_in = (lon_int_sum > 34'(LON_MAX)) ? LON_MAX : lon_int_sum[29:0];
               end
            end
            PH_LON_FRAC: begin
               if (in_char_ff == CH_COMMA) begin
                  phase_in = PH_LON_HEM;
               end else if (!is_dig) begin
                  emit        = 1'b1;
                  emit_status = STATUS_NON_DIGIT;
               end else if (fcount_ff < FRAC_NUM) begin
                  lon_in    = (lon_frac_sum > 31'(LON_MAX)) ? LON_MAX : lon_frac_sum[29:0];
                  fcount_in = fcount_ff + 3'd1;
               end
            end
            PH_LON_HEM: begin
               emit = 1'b1;
               if (in_char_ff == CH_E) begin
                  emit_east = 1'b1;
               end else if (in_char_ff != CH_W) begin
                  emit_status = STATUS_BAD_HEM;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (emit) phase_in = PH_DONE;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         in_start_ff <= req_start_req;
         in_char_ff  <= req_char_in;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tpos_ff   <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         sec_ff    <= '0;
         micro_ff  <= '0;
         fcount_ff <= '0;
         lat_ff    <= '0;
         lon_ff    <= '0;
         north_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         tpos_ff   <= tpos_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         sec_ff    <= sec_in;
         micro_ff  <= micro_in;
         fcount_ff <= fcount_in;
         lat_ff    <= lat_in;
         lon_ff    <= lon_in;
         north_ff  <= north_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && emit) begin
         rsp_hour_ff   <= hour_ff;
         rsp_minute_ff <= minute_ff;
         rsp_second_ff <= sec_ff;
         rsp_micro_ff  <= micro_ff;
         rsp_lat_ff    <= lat_ff;
         rsp_lon_ff    <= lon_ff;
         rsp_north_ff  <= north_ff;
         rsp_east_ff   <= emit_east;
         rsp_status_ff <= emit_status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hour        = rsp_hour_ff;
   assign rsp_minute      = rsp_minute_ff;
   assign rsp_second      = rsp_second_ff;
   assign rsp_microsecond = rsp_micro_ff;
   assign rsp_latitude    = rsp_lat_ff;
   assign rsp_longitude   = rsp_lon_ff;
   assign rsp_north       = rsp_north_ff;
   assign rsp_east        = rsp_east_ff;
   assign rsp_status      = rsp_status_ff;

   // a result always leaves the parser waiting for the next start
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && !in_start_ff) |=> (phase_ff == PH_DONE))
      else $error("parser not done after result");

   // accumulators stay within their saturation limits
   a_sat: assert property (@(posedge clock) disable iff (reset)
      (lat_ff <= LAT_MAX) && (lon_ff <= LON_MAX) && (sec_ff <= SEC_MAX))
      else $error("accumulator beyond saturation limit");

   // an east result is only ever ok
   a_east_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_east_ff) |-> (rsp_status_ff == STATUS_OK))
      else $error("east flag on error result");

   // no result is produced from idle or done
   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_start_ff && (phase_ff == PH_IDLE || phase_ff == PH_DONE))
      |-> !emit)
      else $error("result from idle parser");

   // a pending result never gets overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_status_ff)))
      else $error("pending result lost");

endmodule
